// ----- rtl/core/ipc_pkg.sv -----
// Shared types and codes for the infrared zone people counter.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package ipc_pkg;

   localparam int unsigned ReadingWidth = 16;
   localparam int unsigned OccWidth     = 16;
   localparam int unsigned TotalWidth   = 32;
   localparam int unsigned FillWidth    = 3;
   localparam int unsigned NumSlots     = 3;

   localparam logic [FillWidth-1:0] FillFirst = 3'd1;
   localparam logic [FillWidth-1:0] FillFull  = 3'd4;

   typedef enum logic [1:0] {
      ZONE_OUTSIDE = 2'd0,
      ZONE_FRONT   = 2'd1,
      ZONE_BACK    = 2'd2,
      ZONE_MIDDLE  = 2'd3
   } zone_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_INVALID = 3'd1,
      EV_FILLING = 3'd2,
      EV_ENTER   = 3'd3,
      EV_LEAVE   = 3'd4
   } event_type;

   // path tracker state: last zone, fill count (1..4) and recorded path
   typedef struct packed {
      zone_type                     prev_zone;
      logic [FillWidth-1:0]         fill_count;
      zone_type [NumSlots-1:0]      slot;
   } track_state_type;

   typedef struct packed {
      logic [OccWidth-1:0]   occupancy;
      logic [TotalWidth-1:0] entries;
   } count_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/ipc_track.sv -----
// Zone decision and path pattern tracking for one sample.
// Depends on ipc_pkg.
`default_nettype none

module ipc_track
   import ipc_pkg::*;
(
   input  track_state_type                 state_cur,
   input  logic                            front_flag,
   input  logic                            back_flag,
   input  logic signed [ReadingWidth-1:0]  chan_a_reading,
   input  logic signed [ReadingWidth-1:0]  chan_b_reading,
   input  logic signed [ReadingWidth-1:0]  presence_threshold,
   output track_state_type                 state_nxt,
   output event_type                       event_code
);

   logic                 present;
   logic                 changed;
   zone_type             zone;
   logic [FillWidth-1:0] fill_inc;
   logic [1:0]           slot_idx;

   assign present = (chan_a_reading > presence_threshold) ||
                    (chan_b_reading > presence_threshold);

   always_comb begin
      zone    = ZONE_OUTSIDE;
      changed = 1'b0;
      if (back_flag) begin
         zone    = ZONE_BACK;
         changed = (state_cur.prev_zone != ZONE_BACK);
      end else if (front_flag) begin
         zone    = ZONE_FRONT;
         changed = (state_cur.prev_zone != ZONE_FRONT);
      end else if (present) begin
         // middle only counts right after front or back
         if (state_cur.prev_zone == ZONE_FRONT || state_cur.prev_zone == ZONE_BACK) begin
            zone    = ZONE_MIDDLE;
            changed = 1'b1;
         end
      end else begin
         changed = (state_cur.prev_zone != ZONE_OUTSIDE);
      end
   end

   assign fill_inc = (state_cur.fill_count < FillFull) ?
                     state_cur.fill_count + FillFirst : state_cur.fill_count;

   // long paths keep overwriting the last slot
   always_comb begin
      case (fill_inc)
         3'd2:    slot_idx = 2'd0;
         3'd3:    slot_idx = 2'd1;
         default: slot_idx = 2'd2;
      endcase
   end

   always_comb begin
      state_nxt  = state_cur;
      event_code = EV_NONE;
      if (changed) begin
         state_nxt.prev_zone = zone;
         if (zone == ZONE_OUTSIDE) begin
            state_nxt.fill_count = FillFirst;
            if (fill_inc == FillFull) begin
               if (state_cur.slot[0] == ZONE_FRONT && state_cur.slot[1] == ZONE_MIDDLE &&
                   state_cur.slot[2] == ZONE_BACK) begin
                  event_code = EV_ENTER;
               end else if (state_cur.slot[0] == ZONE_BACK &&
                            state_cur.slot[1] == ZONE_MIDDLE &&
                            state_cur.slot[2] == ZONE_FRONT) begin
                  event_code = EV_LEAVE;
               end else begin
                  event_code = EV_INVALID;
               end
            end
         end else begin
            state_nxt.fill_count     = fill_inc;
            state_nxt.slot[slot_idx] = zone;
            event_code               = EV_FILLING;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ipc_count.sv -----
// Saturating occupancy and entry total update for one event.
// Depends on ipc_pkg.
`default_nettype none

module ipc_count
   import ipc_pkg::*;
(
   input  event_type       event_code,
   input  count_state_type count_cur,
   output count_state_type count_nxt
);

   localparam logic [OccWidth-1:0]   OccMax   = '1;
   localparam logic [TotalWidth-1:0] TotalMax = '1;

   always_comb begin
      count_nxt = count_cur;
      case (event_code)
         EV_ENTER: begin
            if (count_cur.occupancy != OccMax) begin
               count_nxt.occupancy = count_cur.occupancy + OccWidth'(1);
            end
            if (count_cur.entries != TotalMax) begin
               count_nxt.entries = count_cur.entries + TotalWidth'(1);
            end
         end
         EV_LEAVE: begin
            if (count_cur.occupancy != '0) begin
               count_nxt.occupancy = count_cur.occupancy - OccWidth'(1);
            end
         end
         default: begin
            count_nxt = count_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/ir_zone_people_counter_core.sv -----
// Infrared zone people counter. One item per cycle sustained while rsp_ready holds; a
// sample's result reaches rsp through the input register, then the result register, and the
// zone/path state plus counters update as the result register loads. Each item gives
// exactly one result: event code, occupancy and entry total after that sample.
// Write csr_presence_threshold only while no item is in flight.
// Depends on ipc_pkg, ipc_track and ipc_count.
`default_nettype none

module ir_zone_people_counter_core
   import ipc_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_front_flag,
   input  logic                            req_back_flag,
   input  logic signed [ReadingWidth-1:0]  req_chan_a_reading,
   input  logic signed [ReadingWidth-1:0]  req_chan_b_reading,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_event_code,
   output logic [OccWidth-1:0]             rsp_occupancy,
   output logic [TotalWidth-1:0]           rsp_entries_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic signed [ReadingWidth-1:0]  csr_presence_threshold
);

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_front_ff, s1_back_ff;
   logic signed [ReadingWidth-1:0] s1_a_ff, s1_b_ff;
   logic signed [ReadingWidth-1:0] threshold_ff;
   track_state_type                track_ff, track_in;
   count_state_type                count_ff, count_in;
   logic                           out_valid_ff, out_valid_in;
   event_type                      out_event_ff, step_event;
   count_state_type                out_count_ff;
   logic                           advance, fire, req_fire;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = req_fire ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   ipc_track u_track (
      .state_cur          (track_ff),
      .front_flag         (s1_front_ff),
      .back_flag          (s1_back_ff),
      .chan_a_reading     (s1_a_ff),
      .chan_b_reading     (s1_b_ff),
      .presence_threshold (threshold_ff),
      .state_nxt          (track_in),
      .event_code         (step_event)
   );

   ipc_count u_count (
      .event_code (step_event),
      .count_cur  (count_ff),
      .count_nxt  (count_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         threshold_ff            <= '0;
         track_ff.prev_zone      <= ZONE_OUTSIDE;
         track_ff.fill_count     <= FillFirst;
         track_ff.slot           <= '{NumSlots{ZONE_OUTSIDE}};
         count_ff                <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_presence_threshold;
         end
         if (fire) begin
            track_ff <= track_in;
            count_ff <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_front_ff <= req_front_flag;
         s1_back_ff  <= req_back_flag;
         s1_a_ff     <= req_chan_a_reading;
         s1_b_ff     <= req_chan_b_reading;
      end
      if (fire) begin
         out_event_ff <= step_event;
         out_count_ff <= count_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_code    = out_event_ff;
   assign rsp_occupancy     = out_count_ff.occupancy;
   assign rsp_entries_total = out_count_ff.entries;

endmodule

`default_nettype wire

// ----- rtl/core/ipc_checker.sv -----
// Port-level checks for the people counter core, bound to the top level.
// Depends on ipc_pkg and ir_zone_people_counter_core.
`default_nettype none

module ipc_checker
   import ipc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [2:0]            rsp_event_code,
   input logic [OccWidth-1:0]   rsp_occupancy,
   input logic [TotalWidth-1:0] rsp_entries_total
);

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_code <= EV_LEAVE))
      else $error("event code out of range");

   a_enter_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EV_ENTER |-> rsp_entries_total != '0 &&
      rsp_occupancy != '0)
      else $error("entry reported without counts");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code) &&
      $stable(rsp_occupancy) && $stable(rsp_entries_total))
      else $error("stalled result changed");

endmodule

bind ir_zone_people_counter_core ipc_checker u_ipc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_event_code    (rsp_event_code),
   .rsp_occupancy     (rsp_occupancy),
   .rsp_entries_total (rsp_entries_total)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for ir_zone_people_counter_core: a queue-fed driver, a clocked
// monitor and an in-bench zone/path tracker that predicts each sample's report.
// Depends on ipc_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
   import ipc_pkg::*;

   typedef struct {
      logic                           front;
      logic                           back;
      logic signed [ReadingWidth-1:0] chan_a;
      logic signed [ReadingWidth-1:0] chan_b;
   } ir_sample_type;

   typedef struct {
      event_type             ev;
      logic [OccWidth-1:0]   occupancy;
      logic [TotalWidth-1:0] entries;
   } count_report_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_front_flag = 1'b0;
   logic                           req_back_flag = 1'b0;
   logic signed [ReadingWidth-1:0] req_chan_a_reading = '0;
   logic signed [ReadingWidth-1:0] req_chan_b_reading = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [2:0]                     rsp_event_code;
   logic [OccWidth-1:0]            rsp_occupancy;
   logic [TotalWidth-1:0]          rsp_entries_total;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic signed [ReadingWidth-1:0] csr_presence_threshold = '0;

   ir_zone_people_counter_core u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_front_flag         (req_front_flag),
      .req_back_flag          (req_back_flag),
      .req_chan_a_reading     (req_chan_a_reading),
      .req_chan_b_reading     (req_chan_b_reading),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_event_code         (rsp_event_code),
      .rsp_occupancy          (rsp_occupancy),
      .rsp_entries_total      (rsp_entries_total),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_presence_threshold (csr_presence_threshold)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   ir_sample_type    sample_queue[$];
   count_report_type report_queue[$];
   int               send_idle_pct = 35;
   int               recv_idle_pct = 63;
   logic             rx_stall = 1'b0;
   int               mismatches = 0;

   // tracker state, mirrors the block after reset
   logic signed [ReadingWidth-1:0] presence_thr = '0;
   zone_type                       prior_zone = ZONE_OUTSIDE;
   logic [FillWidth-1:0]           fill_count = FillFirst;
   zone_type                       path_slot[NumSlots] = '{ZONE_OUTSIDE, ZONE_OUTSIDE,
                                                           ZONE_OUTSIDE};
   logic [OccWidth-1:0]            occ_count = '0;
   logic [TotalWidth-1:0]          entry_count = '0;

   function automatic count_report_type step_counter(ir_sample_type s);
      count_report_type r;
      zone_type         zone;
      logic             changed;
      int               idx;
      zone    = ZONE_OUTSIDE;
      changed = 1'b0;
      r.ev    = EV_NONE;
      if (s.back) begin
         zone    = ZONE_BACK;
         changed = (prior_zone != ZONE_BACK);
      end else if (s.front) begin
         zone    = ZONE_FRONT;
         changed = (prior_zone != ZONE_FRONT);
      end else if (s.chan_a > presence_thr || s.chan_b > presence_thr) begin
         // middle only counts when coming from front or back
         if (prior_zone == ZONE_FRONT || prior_zone == ZONE_BACK) begin
            zone    = ZONE_MIDDLE;
            changed = 1'b1;
         end
      end else begin
         changed = (prior_zone != ZONE_OUTSIDE);
      end
      if (changed) begin
         if (fill_count < FillFull) fill_count = fill_count + 1'b1;
         if (zone == ZONE_OUTSIDE) begin
            if (fill_count == FillFull) begin
               if (path_slot[0] == ZONE_FRONT && path_slot[1] == ZONE_MIDDLE &&
                   path_slot[2] == ZONE_BACK)
                  r.ev = EV_ENTER;
               else if (path_slot[0] == ZONE_BACK && path_slot[1] == ZONE_MIDDLE &&
                        path_slot[2] == ZONE_FRONT)
                  r.ev = EV_LEAVE;
               else
                  r.ev = EV_INVALID;
            end
            fill_count = FillFirst;
         end else begin
            // long paths keep overwriting the last slot
            idx = (fill_count >= FillFull) ? NumSlots - 1 : int'(fill_count) - 2;
            path_slot[idx] = zone;
            r.ev = EV_FILLING;
         end
         prior_zone = zone;
      end
      if (r.ev == EV_ENTER) begin
         if (occ_count != '1) occ_count = occ_count + 1'b1;
         if (entry_count != '1) entry_count = entry_count + 1'b1;
      end else if (r.ev == EV_LEAVE) begin
         if (occ_count != '0) occ_count = occ_count - 1'b1;
      end
      r.occupancy = occ_count;
      r.entries   = entry_count;
      return r;
   endfunction

   // driver: presents queued samples, predicts each accepted one
   always @(posedge clock) begin
      ir_sample_type cur;
      ir_sample_type taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken.front  = req_front_flag;
            taken.back   = req_back_flag;
            taken.chan_a = req_chan_a_reading;
            taken.chan_b = req_chan_b_reading;
            report_queue.push_back(step_counter(taken));
         end
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur = sample_queue.pop_front();
               req_valid          <= 1'b1;
               req_front_flag     <= cur.front;
               req_back_flag      <= cur.back;
               req_chan_a_reading <= cur.chan_a;
               req_chan_b_reading <= cur.chan_b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each report against the oldest prediction
   always @(posedge clock) begin
      count_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_queue.size() == 0) begin
               $error("report with no item pending: event %0d occ %0d total %0d",
                      rsp_event_code, rsp_occupancy, rsp_entries_total);
               mismatches++;
            end else begin
               want = report_queue.pop_front();
               if (rsp_event_code !== want.ev) begin
                  $error("event_code: expected %0d, got %0d", want.ev, rsp_event_code);
                  mismatches++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
                  mismatches++;
               end
               if (rsp_entries_total !== want.entries) begin
                  $error("entries_total: expected %0d, got %0d", want.entries,
                         rsp_entries_total);
                  mismatches++;
               end
            end
         end
         rsp_ready <= !rx_stall && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic signed [ReadingWidth-1:0] reading_above();
      int t;
      t = presence_thr;
      return 16'(t + 1 + int'($urandom_range(32766 - t)));
   endfunction

   function automatic logic signed [ReadingWidth-1:0] reading_at_most();
      int t;
      t = presence_thr;
      return 16'(int'($urandom_range(t + 32768)) - 32768);
   endfunction

   function automatic ir_sample_type zone_sample(zone_type z);
      ir_sample_type s;
      s.front  = 1'b0;
      s.back   = 1'b0;
      s.chan_a = 16'($urandom_range(16'hffff));
      s.chan_b = 16'($urandom_range(16'hffff));
      case (z)
         ZONE_FRONT: s.front = 1'b1;
         ZONE_BACK: begin
            s.back  = 1'b1;
            s.front = 1'($urandom_range(1));
         end
         ZONE_MIDDLE: begin
            if (presence_thr != 16'sh7fff) begin
               if ($urandom_range(1)) s.chan_a = reading_above();
               else s.chan_b = reading_above();
            end else begin
               // nothing can exceed the top threshold: fall back to outside
               s.chan_a = reading_at_most();
               s.chan_b = reading_at_most();
            end
         end
         default: begin
            s.chan_a = reading_at_most();
            s.chan_b = reading_at_most();
         end
      endcase
      return s;
   endfunction

   function automatic int queue_zone(zone_type z);
      int dwell;
      dwell = $urandom_range(1, 3);
      repeat (dwell) sample_queue.push_back(zone_sample(z));
      return dwell;
   endfunction

   function automatic void queue_sample(logic f, logic b, int a, int c);
      ir_sample_type s;
      s.front  = f;
      s.back   = b;
      s.chan_a = 16'(a);
      s.chan_b = 16'(c);
      sample_queue.push_back(s);
   endfunction

   // mostly complete walks through the zones, some noise and broken paths
   task automatic queue_traffic(int count);
      int            made;
      int            kind;
      int            len;
      zone_type      z;
      ir_sample_type s;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            made += queue_zone(ZONE_FRONT);
            made += queue_zone(ZONE_MIDDLE);
            made += queue_zone(ZONE_BACK);
            made += queue_zone(ZONE_OUTSIDE);
         end else if (kind < 55) begin
            made += queue_zone(ZONE_BACK);
            made += queue_zone(ZONE_MIDDLE);
            made += queue_zone(ZONE_FRONT);
            made += queue_zone(ZONE_OUTSIDE);
         end else if (kind < 80) begin
            len = $urandom_range(1, 5);
            repeat (len) begin
               z = zone_type'(2'($urandom_range(1, 3)));
               made += queue_zone(z);
            end
            made += queue_zone(ZONE_OUTSIDE);
         end else begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               s.front  = 1'($urandom_range(1));
               s.back   = 1'($urandom_range(1));
               s.chan_a = 16'($urandom_range(16'hffff));
               s.chan_b = 16'($urandom_range(16'hffff));
               sample_queue.push_back(s);
               made++;
            end
         end
      end
   endtask

   task automatic drain();
      while (sample_queue.size() != 0 || req_valid || report_queue.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(logic signed [ReadingWidth-1:0] value);
      @(posedge clock);
      csr_valid              <= 1'b1;
      csr_presence_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      presence_thr = value;
      @(negedge clock);
   endtask

   task automatic run_phase(logic signed [ReadingWidth-1:0] thr, int s_idle, int r_idle,
                            int count);
      drain();
      write_threshold(thr);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      queue_traffic(count);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_threshold(16'sd100);

      // directed: extremes, no-prior middle, entry, departures, empty room, long path
      queue_sample(0, 0, -32768, -32768);
      queue_sample(0, 0, 32767, 5);
      queue_sample(1, 0, 32767, -32768);
      queue_sample(1, 0, 0, 0);
      queue_sample(0, 0, 101, -32768);
      queue_sample(0, 0, -1, 32767);
      queue_sample(1, 1, -32768, 32767);
      queue_sample(0, 0, 100, 100);
      queue_sample(0, 1, 0, 0);
      queue_sample(0, 0, -32768, 200);
      queue_sample(1, 0, 50, 50);
      queue_sample(0, 0, 100, -5);
      queue_sample(0, 1, 7, 7);
      queue_sample(0, 0, 300, 300);
      queue_sample(1, 0, 0, 0);
      queue_sample(0, 0, 100, 100);
      queue_sample(1, 0, 1, 1);
      queue_sample(0, 0, 150, 0);
      queue_sample(1, 0, 2, 2);
      queue_sample(0, 0, 0, 101);
      queue_sample(0, 1, 3, 3);
      queue_sample(0, 0, 0, 0);
      queue_sample(1, 0, -100, -100);
      queue_sample(0, 0, 99, 99);

      run_phase(16'($urandom_range(16'hffff)), 35, 63, 320);
      run_phase(-16'sd32768, 35, 63, 180);
      run_phase(16'sd32767, 63, 35, 180);
      run_phase(16'($urandom_range(16'hffff)), 63, 35, 320);

      // long receiver hold while the sender keeps offering
      run_phase(16'sd0, 0, 0, 250);
      rx_stall = 1'b1;
      repeat (300) @(negedge clock);
      rx_stall = 1'b0;

      run_phase(16'($urandom_range(16'hfff)) - 16'sd2048, 0, 0, 300);
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("ir_zone_people_counter_core: match");
      else $display("ir_zone_people_counter_core: mismatch");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("ir_zone_people_counter_core: mismatch");
      $finish;
   end

endmodule
